>>> rtl/core/fsk_zero_crossing_demodulator_top_defines.svh
// Assertion macros for the zero-crossing FSK demodulator.
// Used by fsk_zero_crossing_demodulator_top; expects clk and rst_n in scope.
`ifndef FSK_ZERO_CROSSING_DEMODULATOR_TOP_DEFINES_SVH
`define FSK_ZERO_CROSSING_DEMODULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FZCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FZCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fzcd_pkg.sv
// Shared types and constants for the zero-crossing FSK demodulator.
// No dependencies; the RTL modules refer to it by scoped names.
`timescale 1ns / 1ps
package fzcd_pkg;

  localparam int RING_DEPTH  = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int BAND_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam int POS_BITS    = $clog2(RING_DEPTH);
  localparam int SUM_BITS    = $clog2(RING_DEPTH * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int BAND10_BITS = $clog2(RING_DEPTH * ((2 ** BAND_BITS) - 1) + 1);
  localparam int CMP_BITS    = ((SUM_BITS > BAND10_BITS) ? SUM_BITS : BAND10_BITS) + 2;

  localparam int RING_RESET_VALUE = 700;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SAMPLES_PER_BIT = 2'd0,
    CFG_LOW_THRESH      = 2'd1,
    CFG_HIGH_THRESH     = 2'd2,
    CFG_HYST_BAND       = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_ZERO = 2'd1,
    CLASS_ONE  = 2'd2
  } bit_class_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] samples_per_bit;
    logic [COUNT_BITS-1:0] low_thresh;
    logic [COUNT_BITS-1:0] high_thresh;
    logic [BAND_BITS-1:0]  hyst_band;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/fzcd_front.sv
// Front end: moving-average ring, hysteresis crossing detector, window counter.
// Pushes the crossing count of each finished window into the queue. Uses fzcd_pkg.
`timescale 1ns / 1ps
module fzcd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [fzcd_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic                              in_stall,
  input  fzcd_pkg::cfg_t                    cfg,
  input  fzcd_pkg::q_status_t               q_status,
  output logic                              push,
  output logic [fzcd_pkg::COUNT_BITS-1:0]   push_count
);

  logic [fzcd_pkg::SAMPLE_BITS-1:0] ring_r [fzcd_pkg::RING_DEPTH];
  logic [fzcd_pkg::POS_BITS-1:0]    pos_r, pos_nxt;
  logic [fzcd_pkg::SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [fzcd_pkg::SAMPLE_BITS-1:0] prev_r;
  logic [fzcd_pkg::COUNT_BITS-1:0]  cross_r, cross_nxt;
  logic [fzcd_pkg::COUNT_BITS-1:0]  wnd_r, wnd_nxt;

  logic signed [fzcd_pkg::CMP_BITS-1:0] sum_c, band_c, prev_c, cur_c, lo_lim, hi_lim;
  logic accept, crossing, win_end;

  always_comb begin
    accept  = in_valid && !q_status.full;
    sum_nxt = sum_r - fzcd_pkg::SUM_BITS'(ring_r[pos_r])
                    + fzcd_pkg::SUM_BITS'(in_sample);
    pos_nxt = (pos_r == fzcd_pkg::POS_BITS'(fzcd_pkg::RING_DEPTH - 1)) ?
              '0 : pos_r + 1'b1;

    // Compare at ten times scale so the average stays an integer sum
    sum_c  = fzcd_pkg::CMP_BITS'(sum_nxt);
    band_c = fzcd_pkg::CMP_BITS'(cfg.hyst_band) * fzcd_pkg::CMP_BITS'(fzcd_pkg::RING_DEPTH);
    prev_c = fzcd_pkg::CMP_BITS'(prev_r) * fzcd_pkg::CMP_BITS'(fzcd_pkg::RING_DEPTH);
    cur_c  = fzcd_pkg::CMP_BITS'(in_sample) * fzcd_pkg::CMP_BITS'(fzcd_pkg::RING_DEPTH);
    lo_lim = sum_c - band_c;
    hi_lim = sum_c + band_c;

    crossing = (prev_c < lo_lim && cur_c >= hi_lim) ||
               (prev_c > hi_lim && cur_c <= lo_lim);

    cross_nxt = (crossing && cross_r != fzcd_pkg::COUNT_MAX) ? cross_r + 1'b1 : cross_r;
    wnd_nxt   = (wnd_r != fzcd_pkg::COUNT_MAX) ? wnd_r + 1'b1 : wnd_r;
    win_end   = (wnd_nxt >= cfg.samples_per_bit);

    push       = accept && win_end;
    push_count = cross_nxt;
    in_stall   = q_status.full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fzcd_pkg::RING_DEPTH; i++) begin
        ring_r[i] <= fzcd_pkg::SAMPLE_BITS'(fzcd_pkg::RING_RESET_VALUE);
      end
      pos_r   <= '0;
      sum_r   <= fzcd_pkg::SUM_BITS'(fzcd_pkg::RING_RESET_VALUE * fzcd_pkg::RING_DEPTH);
      prev_r  <= '0;
      cross_r <= '0;
      wnd_r   <= '0;
    end else if (accept) begin
      ring_r[pos_r] <= in_sample;
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt;
      prev_r        <= in_sample;
      if (win_end) begin
        cross_r <= '0;
        wnd_r   <= '0;
      end else begin
        cross_r <= cross_nxt;
        wnd_r   <= wnd_nxt;
      end
    end
  end

endmodule

>>> rtl/core/fzcd_queue.sv
// Short FIFO of window crossing counts between front and back end.
// Uses fzcd_pkg for depth and widths.
`timescale 1ns / 1ps
module fzcd_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [fzcd_pkg::COUNT_BITS-1:0]  push_count,
  input  logic                             pop,
  output logic [fzcd_pkg::COUNT_BITS-1:0]  head_count,
  output fzcd_pkg::q_status_t              status
);

  logic [fzcd_pkg::COUNT_BITS-1:0] mem_r [fzcd_pkg::QUEUE_DEPTH];
  logic [fzcd_pkg::QPTR_BITS-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [fzcd_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic do_push, do_pop;

  always_comb begin
    status.full  = (cnt_r == fzcd_pkg::QCNT_BITS'(fzcd_pkg::QUEUE_DEPTH));
    status.empty = (cnt_r == '0);
    do_push = push && !status.full;
    do_pop  = pop && !status.empty;
    wr_nxt  = (wr_r == fzcd_pkg::QPTR_BITS'(fzcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == fzcd_pkg::QPTR_BITS'(fzcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    head_count = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_nxt;
      end
      if (do_pop) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/fzcd_back.sv
// Back end: classify each window count, assemble bytes MSB first,
// hold the result in the output register. Uses fzcd_pkg.
`timescale 1ns / 1ps
module fzcd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fzcd_pkg::cfg_t                   cfg,
  input  fzcd_pkg::q_status_t              q_status,
  input  logic [fzcd_pkg::COUNT_BITS-1:0]  head_count,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_bit_class,
  output logic [fzcd_pkg::COUNT_BITS-1:0]  out_crossing_count,
  output logic                             out_byte_valid,
  output logic [7:0]                       out_byte_value
);

  logic                      valid_r;
  logic [1:0]                class_r;
  logic [fzcd_pkg::COUNT_BITS-1:0] count_r;
  logic                      bvalid_r, bvalid_nxt;
  logic [7:0]                bvalue_r, bvalue_nxt;
  logic [7:0]                shift_r, shift_nxt;
  logic [2:0]                held_r, held_nxt;
  fzcd_pkg::bit_class_t      cls;
  logic [7:0]                shifted;

  always_comb begin
    pop = !q_status.empty && (!valid_r || !out_stall);

    if (head_count >= cfg.low_thresh && head_count < cfg.high_thresh) begin
      cls = fzcd_pkg::CLASS_ZERO;
    end else if (head_count >= cfg.high_thresh) begin
      cls = fzcd_pkg::CLASS_ONE;
    end else begin
      cls = fzcd_pkg::CLASS_NONE;
    end

    shifted    = {shift_r[6:0], (cls == fzcd_pkg::CLASS_ONE)};
    shift_nxt  = shift_r;
    held_nxt   = held_r;
    bvalid_nxt = 1'b0;
    bvalue_nxt = '0;
    if (cls != fzcd_pkg::CLASS_NONE) begin
      if (held_r == 3'd7) begin
        bvalid_nxt = 1'b1;
        bvalue_nxt = shifted;
        shift_nxt  = '0;
        held_nxt   = '0;
      end else begin
        shift_nxt = shifted;
        held_nxt  = held_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      shift_r <= '0;
      held_r  <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload loads with each pop; no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      class_r  <= cls;
      count_r  <= head_count;
      bvalid_r <= bvalid_nxt;
      bvalue_r <= bvalue_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_bit_class      = class_r;
  assign out_crossing_count = count_r;
  assign out_byte_valid     = bvalid_r;
  assign out_byte_value     = bvalue_r;

endmodule

>>> rtl/core/fsk_zero_crossing_demodulator_top.sv
// Zero-crossing FSK demodulator top: config registers, front end, queue, back end.
// Throughput: a sample per cycle unless stalled; one result per samples_per_bit window.
// Path: a window count is queued, then popped into the output register (out_valid).
// Stalls: in_stall rises only while two window results wait behind a held output.
// Reset (synchronous, rst_n low): ring entries 700, sum 7000, counters and byte cleared,
// registers to 1000 / 180 / 360 / 5; queue and output register empty.
`timescale 1ns / 1ps
`include "fsk_zero_crossing_demodulator_top_defines.svh"
module fsk_zero_crossing_demodulator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  input  logic [fzcd_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic                                in_stall,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_bit_class,
  output logic [fzcd_pkg::COUNT_BITS-1:0]     out_crossing_count,
  output logic                                out_byte_valid,
  output logic [7:0]                          out_byte_value,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [fzcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fzcd_pkg::COUNT_BITS-1:0]     cfg_wdata
);

  fzcd_pkg::cfg_t      cfg_r;
  fzcd_pkg::q_status_t q_status;
  logic                               push, pop;
  logic [fzcd_pkg::COUNT_BITS-1:0]    push_count, head_count;

  // Configuration registers: take a write on any edge with cfg_we high.
  // The host must write only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_bit <= 16'd1000;
      cfg_r.low_thresh      <= 16'd180;
      cfg_r.high_thresh     <= 16'd360;
      cfg_r.hyst_band       <= 8'd5;
    end else if (cfg_we) begin
      case (fzcd_pkg::cfg_index_t'(cfg_index))
        fzcd_pkg::CFG_SAMPLES_PER_BIT: cfg_r.samples_per_bit <= cfg_wdata;
        fzcd_pkg::CFG_LOW_THRESH:      cfg_r.low_thresh      <= cfg_wdata;
        fzcd_pkg::CFG_HIGH_THRESH:     cfg_r.high_thresh     <= cfg_wdata;
        fzcd_pkg::CFG_HYST_BAND:       cfg_r.hyst_band       <= cfg_wdata[fzcd_pkg::BAND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: every accepted sample updates the average and the crossing
  // count; the last sample of a window pushes one transaction into the queue.
  // Stall the sample channel only while the queue is full.
  fzcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_sample  (in_sample),
    .in_stall   (in_stall),
    .cfg        (cfg_r),
    .q_status   (q_status),
    .push       (push),
    .push_count (push_count)
  );

  // Queue: decouples the sample stream from a stalled result channel.
  fzcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_count (push_count),
    .pop        (pop),
    .head_count (head_count),
    .status     (q_status)
  );

  // Back end: classify, shift bits into the byte, and hold the result
  // transaction in the output register until taken.
  fzcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_status           (q_status),
    .head_count         (head_count),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bit_class      (out_bit_class),
    .out_crossing_count (out_crossing_count),
    .out_byte_valid     (out_byte_valid),
    .out_byte_value     (out_byte_value)
  );

  // A push never hits a full queue: the front end stalls first.
  `FZCD_ASSERT_NOW(a_no_overflow, push, !q_status.full, "push into full queue")
  // A completed byte only comes with a valid bit, and its LSB is that bit.
  `FZCD_ASSERT_NOW(a_byte_has_bit, out_valid && out_byte_valid,
    out_bit_class != fzcd_pkg::CLASS_NONE, "byte completed without a bit")
  `FZCD_ASSERT_NOW(a_byte_lsb, out_valid && out_byte_valid,
    out_byte_value[0] == (out_bit_class == fzcd_pkg::CLASS_ONE), "byte LSB mismatch")
  // A pop always leaves a result in the output register.
  `FZCD_ASSERT_NEXT(a_pop_loads, pop, out_valid, "pop did not load output")

endmodule
